// ----- sv/p2y_pkg.sv -----
// ----------------------------------------------------------------------------
// p2y_pkg
// Shared types and constants for the palette to YCbCr 4:2:2 packer.
// ----------------------------------------------------------------------------
`default_nettype none

package p2y_pkg;

    // request codes on the input channel
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_PIXEL = 1'b1
    } t_req;

    // one palette entry as stored: {y, cb, cr}
    localparam int ENTRY_W = 24;

    // luma weights (sum fits 18 bits)
    localparam logic [17:0] Y_R_W = 18'd299;
    localparam logic [17:0] Y_G_W = 18'd587;
    localparam logic [17:0] Y_B_W = 18'd114;

    // chroma weights as magnitudes, signs applied in the datapath
    localparam logic signed [26:0] CB_R_W     = 27'sd16874;
    localparam logic signed [26:0] CB_G_W     = 27'sd33126;
    localparam logic signed [26:0] CB_B_W     = 27'sd50000;
    localparam logic signed [26:0] CR_R_W     = 27'sd50000;
    localparam logic signed [26:0] CR_G_W     = 27'sd41869;
    localparam logic signed [26:0] CR_B_W     = 27'sd8131;
    localparam logic signed [26:0] CHROMA_OFS = 27'sd12800000;

    // reciprocal multipliers: exact floor division over the reachable sums
    // y  : sum < 2^18, divide by 1000   -> ceil(2^28 / 1000)
    // c  : sum < 2^25, divide by 100000 -> ceil(2^41 / 100000)
    localparam logic [18:0] Y_RECIP = 19'd268436;
    localparam int          Y_SHIFT = 28;
    localparam logic [24:0] C_RECIP = 25'd21990233;
    localparam int          C_SHIFT = 41;

endpackage

`default_nettype wire

// ----- sv/p2y_ram.sv -----
// ----------------------------------------------------------------------------
// p2y_ram
// Generic RAM: one write port, two read ports, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module p2y_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- sv/palette_to_ycbcr422_packer.sv -----
// ----------------------------------------------------------------------------
// palette_to_ycbcr422_packer
// Palette-indexed pixel pairs to packed Y Cb Y Cr 4:2:2 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries two kinds of transfer.
//   A palette write (req_type 0) converts red, green, blue to full-range
//   BT.601 Y, Cb, Cr and stores them at entry_index; it produces no output.
//   A pixel pair (req_type 1) looks up left_index and right_index and gives
//   one output transfer (o_out_valid / i_out_ready) with both lumas and the
//   truncated averages of Cb and Cr.
//   Throughput: one item per clock cycle, any mix of writes and pixels,
//   while the output is not stalled. A pixel pair passes the input stage,
//   the palette RAM read stage and the output register in that order;
//   o_out_valid rises when the output register loads it.
//   A palette write reaches the RAM when it leaves the RAM read stage; a
//   pixel that reads the entry while that write is in the RAM read stage
//   takes the value from a bypass path.
//   Indices at or above PALETTE_ENTRIES read as zero; writes there are
//   dropped. Entries never written read undefined data.
//   Reset empties the pipeline; the palette RAM itself is not cleared.
//   When the receiver stalls, the output register holds its word, and the
//   input keeps being taken until the pipeline stages behind it are full.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_to_ycbcr422_packer
    import p2y_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_entry_index,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_left_index,
    input  wire logic [7:0] i_right_index,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_luma_left,
    output logic [7:0]      o_chroma_blue,
    output logic [7:0]      o_luma_right,
    output logic [7:0]      o_chroma_red
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] N_ENTRIES = 9'(PALETTE_ENTRIES);

    // stage 1: weighted sums or pixel indices
    logic                r_s1_valid;
    t_req                r_s1_req;
    logic [7:0]          r_s1_entry_index;
    logic                r_s1_wr_ok;
    logic [17:0]         r_s1_sum_y;
    logic [24:0]         r_s1_sum_cb;
    logic [24:0]         r_s1_sum_cr;
    logic [7:0]          r_s1_left_index;
    logic [7:0]          r_s1_right_index;
    logic                r_s1_left_ok;
    logic                r_s1_right_ok;

    // stage 2: converted entry / RAM read data
    logic                r_s2_valid;
    t_req                r_s2_req;
    logic [7:0]          r_s2_entry_index;
    logic                r_s2_wr_ok;
    logic [ENTRY_W-1:0]  r_s2_data;
    logic                r_s2_left_ok;
    logic                r_s2_right_ok;
    logic                r_s2_fwd_left;
    logic                r_s2_fwd_right;
    logic [ENTRY_W-1:0]  r_s2_fwd_data;

    // output register
    logic                r_out_valid;
    logic [7:0]          r_luma_left;
    logic [7:0]          r_chroma_blue;
    logic [7:0]          r_luma_right;
    logic [7:0]          r_chroma_red;

    logic                in_xfer;
    logic                s1_adv;
    logic                s2_adv;
    logic                s2_free;
    logic                out_load;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_rdata_l;
    logic [ENTRY_W-1:0]  ram_rdata_r;
    logic [17:0]         w_sum_y;
    logic signed [26:0]  w_sum_cb;
    logic signed [26:0]  w_sum_cr;
    logic [36:0]         y_prod;
    logic [49:0]         cb_prod;
    logic [49:0]         cr_prod;
    logic [ENTRY_W-1:0]  conv_data;
    logic                fwd_left;
    logic                fwd_right;
    logic [ENTRY_W-1:0]  entry_l;
    logic [ENTRY_W-1:0]  entry_r;
    logic [8:0]          cb_sum;
    logic [8:0]          cr_sum;
    logic [7:0]          n_luma_left;
    logic [7:0]          n_chroma_blue;
    logic [7:0]          n_luma_right;
    logic [7:0]          n_chroma_red;

    // pipeline flow: writes always leave stage 2, pixels need the output slot
    assign s2_adv     = r_s2_valid &&
                        ((r_s2_req == REQ_WRITE) || !r_out_valid || i_out_ready);
    assign s2_free    = !r_s2_valid || s2_adv;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = s2_adv && (r_s2_req == REQ_PIXEL);

    // weighted sums from the input color, all chroma sums are non-negative
    assign w_sum_y  = Y_R_W * 18'(i_red) + Y_G_W * 18'(i_green) + Y_B_W * 18'(i_blue);
    assign w_sum_cb = CHROMA_OFS + CB_B_W * $signed(27'(i_blue))
                    - CB_R_W * $signed(27'(i_red)) - CB_G_W * $signed(27'(i_green));
    assign w_sum_cr = CHROMA_OFS + CR_R_W * $signed(27'(i_red))
                    - CR_G_W * $signed(27'(i_green)) - CR_B_W * $signed(27'(i_blue));

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_req         <= t_req'(i_req_type);
            r_s1_entry_index <= i_entry_index;
            r_s1_wr_ok       <= {1'b0, i_entry_index} < N_ENTRIES;
            r_s1_sum_y       <= w_sum_y;
            r_s1_sum_cb      <= w_sum_cb[24:0];
            r_s1_sum_cr      <= w_sum_cr[24:0];
            r_s1_left_index  <= i_left_index;
            r_s1_right_index <= i_right_index;
            r_s1_left_ok     <= {1'b0, i_left_index} < N_ENTRIES;
            r_s1_right_ok    <= {1'b0, i_right_index} < N_ENTRIES;
        end
    end

    // constant division by reciprocal multiply
    assign y_prod    = 37'(r_s1_sum_y) * 37'(Y_RECIP);
    assign cb_prod   = 50'(r_s1_sum_cb) * 50'(C_RECIP);
    assign cr_prod   = 50'(r_s1_sum_cr) * 50'(C_RECIP);
    assign conv_data = {y_prod[Y_SHIFT +: 8], cb_prod[C_SHIFT +: 8], cr_prod[C_SHIFT +: 8]};

    // bypass: the write in stage 2 lands in RAM at the same edge as this read
    assign fwd_left  = r_s2_valid && (r_s2_req == REQ_WRITE) && r_s2_wr_ok &&
                       (r_s2_entry_index == r_s1_left_index);
    assign fwd_right = r_s2_valid && (r_s2_req == REQ_WRITE) && r_s2_wr_ok &&
                       (r_s2_entry_index == r_s1_right_index);

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_req         <= r_s1_req;
            r_s2_entry_index <= r_s1_entry_index;
            r_s2_wr_ok       <= r_s1_wr_ok;
            r_s2_data        <= conv_data;
            r_s2_left_ok     <= r_s1_left_ok;
            r_s2_right_ok    <= r_s1_right_ok;
            r_s2_fwd_left    <= fwd_left;
            r_s2_fwd_right   <= fwd_right;
            r_s2_fwd_data    <= r_s2_data;
        end
    end

    // palette store
    assign ram_we = s2_adv && (r_s2_req == REQ_WRITE) && r_s2_wr_ok;

    p2y_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_s2_entry_index[AW-1:0]),
        .i_wdata   (r_s2_data),
        .i_re      (s1_adv),
        .i_raddr_a (r_s1_left_index[AW-1:0]),
        .i_raddr_b (r_s1_right_index[AW-1:0]),
        .o_rdata_a (ram_rdata_l),
        .o_rdata_b (ram_rdata_r)
    );

    // entry select, out-of-range reads as zero, then chroma averaging
    always_comb begin
        entry_l = r_s2_fwd_left  ? r_s2_fwd_data : ram_rdata_l;
        entry_r = r_s2_fwd_right ? r_s2_fwd_data : ram_rdata_r;
        if (!r_s2_left_ok) begin
            entry_l = '0;
        end
        if (!r_s2_right_ok) begin
            entry_r = '0;
        end
        cb_sum        = {1'b0, entry_l[15:8]} + {1'b0, entry_r[15:8]};
        cr_sum        = {1'b0, entry_l[7:0]} + {1'b0, entry_r[7:0]};
        n_luma_left   = entry_l[23:16];
        n_chroma_blue = cb_sum[8:1];
        n_luma_right  = entry_r[23:16];
        n_chroma_red  = cr_sum[8:1];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_luma_left   <= n_luma_left;
            r_chroma_blue <= n_chroma_blue;
            r_luma_right  <= n_luma_right;
            r_chroma_red  <= n_chroma_red;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_luma_left   = r_luma_left;
    assign o_chroma_blue = r_chroma_blue;
    assign o_luma_right  = r_luma_right;
    assign o_chroma_red  = r_chroma_red;

endmodule

`default_nettype wire

// ----- sv/p2y_checker.sv -----
// ----------------------------------------------------------------------------
// p2y_checker
// Port-level checks for the palette to YCbCr 4:2:2 packer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module p2y_checker
    import p2y_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       i_req_type,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_luma_left,
    input wire logic [7:0] o_chroma_blue,
    input wire logic [7:0] o_luma_right,
    input wire logic [7:0] o_chroma_red
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled output word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_luma_left) && $stable(o_chroma_blue)
                                        && $stable(o_luma_right) && $stable(o_chroma_red))
        else $error("output payload changed while stalled");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    // a pixel pair reaches the output through stage 1, stage 2 and the output register when not stalled
    a_pixel_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_req_type == REQ_PIXEL))
            ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("pixel pair did not reach the output in time");

endmodule

bind palette_to_ycbcr422_packer p2y_checker u_p2y_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_luma_left   (o_luma_left),
    .o_chroma_blue (o_chroma_blue),
    .o_luma_right  (o_luma_right),
    .o_chroma_red  (o_chroma_red)
);

`default_nettype wire
